>>> rtl/core/mlfq_pkg.sv
// shared types, constants and helpers for the multilevel feedback queue scheduler
// no dependencies; compiled first
package mlfq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int LEVELS      = 3;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LVL_IDX_W   = $clog2(LEVELS);

  // field widths
  localparam int ID_W      = 8;
  localparam int TIME_W    = 16;
  localparam int LVL_W     = 2;
  localparam int CFG_IDX_W = 2;

  // level codes as reported on the result channel
  localparam logic [LVL_W-1:0] LVL_ONE   = 2'd1;
  localparam logic [LVL_W-1:0] LVL_TWO   = 2'd2;
  localparam logic [LVL_W-1:0] LVL_THREE = 2'd3;

  // item operation codes
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUANTUM_L1 = 2'd0,
    CFG_QUANTUM_L2 = 2'd1,
    CFG_QUANTUM_L3 = 2'd2
  } cfg_idx_t;

  // one queued task
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] need;
    logic [TIME_W-1:0] runtime;
  } task_t;

  // control into one level fifo
  typedef struct packed {
    logic  push;
    logic  pop;
    task_t wdata;
  } fifo_ctl_t;

  // status out of one level fifo
  typedef struct packed {
    logic [CNT_W-1:0] count;
    task_t            head;
  } fifo_sts_t;

  // circular pointer advance
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

endpackage

>>> rtl/core/mlfq_in_if.sv
// input channel of the scheduler: valid/ready handshake with add/step payload
// depends on mlfq_pkg for field widths
interface mlfq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [mlfq_pkg::ID_W-1:0]   task_id;
  logic [mlfq_pkg::TIME_W-1:0] need_time;

  modport source (output valid, output op, output task_id, output need_time, input ready);
  modport sink   (input valid, input op, input task_id, input need_time, output ready);
endinterface

>>> rtl/core/mlfq_out_if.sv
// result channel of the scheduler: valid/ready handshake with one result per item
// depends on mlfq_pkg for field widths
interface mlfq_out_if;
  logic                        valid;
  logic                        ready;
  logic                        add_accepted;
  logic                        ran_valid;
  logic [mlfq_pkg::ID_W-1:0]   ran_id;
  logic [mlfq_pkg::TIME_W-1:0] ran_runtime;
  logic [mlfq_pkg::LVL_W-1:0]  ran_level;
  logic                        finished;
  logic                        idle;

  modport source (output valid, output add_accepted, output ran_valid, output ran_id,
                  output ran_runtime, output ran_level, output finished, output idle,
                  input ready);
  modport sink   (input valid, input add_accepted, input ran_valid, input ran_id,
                  input ran_runtime, input ran_level, input finished, input idle,
                  output ready);
endinterface

>>> rtl/core/multilevel_feedback_queue_scheduler.sv
// top level of the three-level feedback queue scheduler
// depends on mlfq_pkg, mlfq_in_if, mlfq_out_if and mlfq_fifo
//
// usage:
//   in  channel: op selects add (task_id, need_time) or one scheduling step.
//   out channel: one result per item (add_accepted, ran_* of the task that ran,
//                finished, idle after the item).
//   cfg port: cfg_we writes cfg_wdata to quantum register cfg_idx (0..2);
//             writes to index 3 are ignored. write only while the block is idle.
// timing:
//   an item transferred in is held in an input register, processed in
//   combinational logic (queue pop, add-and-clamp, requeue) and lands in the
//   result register at the next rising edge, from where it can transfer out.
//   throughput is one item per cycle while out.ready stays high, set by the
//   combinational state update.
// reset:
//   rst_n (synchronous, active low) empties the ready slot and all queues and
//   loads the quanta 1, 2 and 3. queue entries themselves are not cleared.
// stall:
//   while the result register is full and out.ready is low, the pending input
//   item is held and in.ready drops once the input register is also occupied.
module multilevel_feedback_queue_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,
  mlfq_in_if.sink                           in_if,
  mlfq_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [mlfq_pkg::TIME_W-1:0]       cfg_wdata
);
  import mlfq_pkg::*;

  // quantum registers
  logic [TIME_W-1:0] quantum_r [LEVELS];

  // input register
  logic              in_vld_r;
  logic              in_op_r;
  logic [ID_W-1:0]   in_id_r;
  logic [TIME_W-1:0] in_need_r;

  // ready slot
  logic              slot_vld_r;
  logic              slot_vld_nxt;
  task_t             slot_task_r;
  task_t             slot_task_nxt;
  logic [LVL_W-1:0]  slot_lvl_r;
  logic [LVL_W-1:0]  slot_lvl_nxt;

  // result register
  logic              out_vld_r;
  logic              out_acc_r;
  logic              out_acc_nxt;
  logic              out_ran_r;
  logic              out_ran_nxt;
  logic [ID_W-1:0]   out_id_r;
  logic [ID_W-1:0]   out_id_nxt;
  logic [TIME_W-1:0] out_rt_r;
  logic [TIME_W-1:0] out_rt_nxt;
  logic [LVL_W-1:0]  out_lvl_r;
  logic [LVL_W-1:0]  out_lvl_nxt;
  logic              out_fin_r;
  logic              out_fin_nxt;
  logic              out_idle_r;
  logic              out_idle_nxt;

  // fifo links
  fifo_ctl_t         ctl [LEVELS];
  fifo_sts_t         sts [LEVELS];

  // datapath
  logic              go;
  logic              in_xfer;
  logic [LVL_W-1:0]  cur_lvl;
  logic [LVL_W-1:0]  new_lvl;
  logic [TIME_W-1:0] cur_q;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] new_rt;
  logic              unfinished;
  logic              any_queued;
  logic [LVL_IDX_W-1:0] pop_idx;
  logic [LVL_IDX_W-1:0] push_idx;
  logic              push_room;
  task_t             ran_task;
  task_t             add_task;
  logic [LEVELS-1:0] empty_after;

  // handshake
  assign go          = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || go;
  assign in_xfer     = in_if.valid && in_if.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r[0] <= TIME_W'(1);
      quantum_r[1] <= TIME_W'(2);
      quantum_r[2] <= TIME_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_QUANTUM_L1: quantum_r[0] <= cfg_wdata;
        CFG_QUANTUM_L2: quantum_r[1] <= cfg_wdata;
        CFG_QUANTUM_L3: quantum_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_xfer || (in_vld_r && !go);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_op_r   <= in_if.op;
      in_id_r   <= in_if.task_id;
      in_need_r <= in_if.need_time;
    end
  end

  // level queues
  for (genvar g = 0; g < LEVELS; g++) begin : g_level
    mlfq_fifo u_fifo (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl[g]),
      .sts   (sts[g])
    );
  end

  // runtime credit and demotion of the running task
  always_comb begin
    cur_lvl = (slot_lvl_r == '0) ? LVL_ONE : slot_lvl_r;
    unique case (cur_lvl)
      LVL_TWO:   cur_q = quantum_r[1];
      LVL_THREE: cur_q = quantum_r[2];
      default:   cur_q = quantum_r[0];
    endcase
    sum        = {1'b0, slot_task_r.runtime} + {1'b0, cur_q};
    new_rt     = (sum > {1'b0, slot_task_r.need}) ? slot_task_r.need : sum[TIME_W-1:0];
    new_lvl    = (cur_lvl == LVL_THREE) ? LVL_THREE : cur_lvl + LVL_W'(1);
    unfinished = new_rt < slot_task_r.need;
    push_idx   = LVL_IDX_W'(new_lvl - LVL_W'(1));
    ran_task   = '{id: slot_task_r.id, need: slot_task_r.need, runtime: new_rt};
    add_task   = '{id: in_id_r, need: in_need_r, runtime: '0};
  end

  // highest non-empty level
  always_comb begin
    any_queued = 1'b1;
    pop_idx    = '0;
    priority if (sts[0].count != '0) begin
      pop_idx = LVL_IDX_W'(0);
    end else if (sts[1].count != '0) begin
      pop_idx = LVL_IDX_W'(1);
    end else if (sts[2].count != '0) begin
      pop_idx = LVL_IDX_W'(2);
    end else begin
      any_queued = 1'b0;
    end
    // room at the requeue level, counting a pop from that same level
    push_room = (sts[push_idx].count != CNT_W'(QUEUE_DEPTH)) ||
                (any_queued && pop_idx == push_idx);
  end

  // item processing
  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      ctl[i].push  = 1'b0;
      ctl[i].pop   = 1'b0;
      ctl[i].wdata = ran_task;
    end
    slot_vld_nxt  = slot_vld_r;
    slot_task_nxt = slot_task_r;
    slot_lvl_nxt  = slot_lvl_r;
    out_acc_nxt   = 1'b0;
    out_ran_nxt   = 1'b0;
    out_id_nxt    = '0;
    out_rt_nxt    = '0;
    out_lvl_nxt   = '0;
    out_fin_nxt   = 1'b0;
    if (go) begin
      if (in_op_r == OP_ADD) begin
        if (!slot_vld_r) begin
          slot_vld_nxt  = 1'b1;
          slot_task_nxt = add_task;
          slot_lvl_nxt  = LVL_ONE;
          out_acc_nxt   = 1'b1;
        end else if (sts[0].count != CNT_W'(QUEUE_DEPTH)) begin
          ctl[0].push  = 1'b1;
          ctl[0].wdata = add_task;
          out_acc_nxt  = 1'b1;
        end
      end else if (slot_vld_r) begin
        out_ran_nxt = 1'b1;
        out_id_nxt  = slot_task_r.id;
        out_rt_nxt  = new_rt;
        out_lvl_nxt = new_lvl;
        out_fin_nxt = !unfinished;
        if (any_queued) begin
          // refill from the queue, requeue the task that ran
          ctl[pop_idx].pop = 1'b1;
          slot_task_nxt    = sts[pop_idx].head;
          slot_lvl_nxt     = LVL_W'(pop_idx) + LVL_W'(1);
          if (unfinished && push_room) begin
            ctl[push_idx].push = 1'b1;
          end
        end else begin
          // queues empty: the task that ran goes straight back to the slot if unfinished
          slot_vld_nxt  = unfinished;
          slot_task_nxt = ran_task;
          slot_lvl_nxt  = new_lvl;
        end
      end
    end
  end

  // emptiness after this item
  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      empty_after[i] = ((sts[i].count == '0) && !ctl[i].push) ||
                       ((sts[i].count == CNT_W'(1)) && ctl[i].pop && !ctl[i].push);
    end
    out_idle_nxt = !slot_vld_nxt && (&empty_after);
  end

  // ready slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= 1'b0;
      slot_lvl_r <= LVL_ONE;
    end else begin
      slot_vld_r <= slot_vld_nxt;
      slot_lvl_r <= slot_lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_task_r <= slot_task_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= go || (out_vld_r && !out_if.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_acc_r  <= out_acc_nxt;
      out_ran_r  <= out_ran_nxt;
      out_id_r   <= out_id_nxt;
      out_rt_r   <= out_rt_nxt;
      out_lvl_r  <= out_lvl_nxt;
      out_fin_r  <= out_fin_nxt;
      out_idle_r <= out_idle_nxt;
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.add_accepted = out_acc_r;
  assign out_if.ran_valid    = out_ran_r;
  assign out_if.ran_id       = out_id_r;
  assign out_if.ran_runtime  = out_rt_r;
  assign out_if.ran_level    = out_lvl_r;
  assign out_if.finished     = out_fin_r;
  assign out_if.idle         = out_idle_r;

  // an empty ready slot means every queue is empty
  a_slot_empty_queues_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !slot_vld_r |-> (sts[0].count == '0 && sts[1].count == '0 && sts[2].count == '0))
    else $error("queued task while ready slot is empty");

  // slot level stays within one to three
  a_slot_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_vld_r |-> slot_lvl_r != '0)
    else $error("ready slot holds level zero");

  // occupancy never exceeds the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts[0].count <= CNT_W'(QUEUE_DEPTH) && sts[1].count <= CNT_W'(QUEUE_DEPTH) &&
    sts[2].count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // a step with nothing ready leaves the slot empty
  a_idle_step_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (go && in_op_r == OP_STEP && !slot_vld_r) |=> !slot_vld_r)
    else $error("empty step changed the ready slot");

  // finished is only reported for a task that ran
  a_finished_ran: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_fin_r) |-> out_ran_r)
    else $error("finished without a task run");

endmodule

>>> rtl/core/mlfq_fifo.sv
// one level queue: register file with head/tail pointers and an occupancy count
// depends on mlfq_pkg; push and pop may both occur in the same cycle
module mlfq_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  mlfq_pkg::fifo_ctl_t ctl,
  output mlfq_pkg::fifo_sts_t sts
);
  import mlfq_pkg::*;

  task_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] head_r;
  logic [PTR_W-1:0] head_nxt;
  logic [PTR_W-1:0] tail_r;
  logic [PTR_W-1:0] tail_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // entry storage, written at the tail
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[tail_r] <= ctl.wdata;
    end
  end

  // pointer and count update
  always_comb begin
    head_nxt  = ctl.pop  ? ptr_inc(head_r) : head_r;
    tail_nxt  = ctl.push ? ptr_inc(tail_r) : tail_r;
    count_nxt = count_r;
    unique case ({ctl.push, ctl.pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // status toward the scheduler
  assign sts.count = count_r;
  assign sts.head  = mem_r[head_r];

endmodule

>>> tb/tb_multilevel_feedback_queue_scheduler.sv
`timescale 1ns / 1ps
// self-checking testbench for the three-level feedback queue scheduler
// depends on mlfq_pkg, mlfq_in_if, mlfq_out_if and the scheduler rtl
// an in-bench scheduler model predicts every result; directed cases, then random traffic
module tb_multilevel_feedback_queue_scheduler;
  import mlfq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  // one result item as seen on the out channel
  typedef struct packed {
    logic              add_accepted;
    logic              ran_valid;
    logic [ID_W-1:0]   ran_id;
    logic [TIME_W-1:0] ran_runtime;
    logic [LVL_W-1:0]  ran_level;
    logic              finished;
    logic              idle;
  } sched_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [TIME_W-1:0]    cfg_wdata;

  mlfq_in_if  in_ch ();
  mlfq_out_if out_ch ();

  multilevel_feedback_queue_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // scheduler model state
  task_t             level_fifo [LEVELS][$];
  logic              slot_valid;
  task_t             slot_task;
  int unsigned       slot_level;
  logic [TIME_W-1:0] quantum_cfg [LEVELS];

  sched_result_t expected_outcomes [$];
  int unsigned   mismatch_count;
  int unsigned   quiet_cycles;
  int unsigned   send_gap_pct;
  int unsigned   stall_pct;

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // model: move the head of the highest non-empty level into the ready slot
  function automatic void refill_slot();
    slot_valid = 1'b0;
    for (int lv = 0; lv < LEVELS; lv++) begin
      if (!slot_valid && level_fifo[lv].size() != 0) begin
        slot_task  = level_fifo[lv].pop_front();
        slot_level = lv + 1;
        slot_valid = 1'b1;
      end
    end
  endfunction

  // model: apply one accepted item, return the result it produces
  function automatic sched_result_t schedule_item(op_t op, logic [ID_W-1:0] id,
                                                  logic [TIME_W-1:0] need);
    sched_result_t     res;
    task_t             ran;
    int unsigned       lv;
    logic [TIME_W:0]   sum;
    logic              pushed;
    res = '0;
    if (op == OP_ADD) begin
      ran.id      = id;
      ran.need    = need;
      ran.runtime = '0;
      if (!slot_valid) begin
        slot_task    = ran;
        slot_level   = 1;
        slot_valid   = 1'b1;
        res.add_accepted = 1'b1;
      end else if (level_fifo[0].size() < QUEUE_DEPTH) begin
        level_fifo[0].push_back(ran);
        res.add_accepted = 1'b1;
      end
    end else if (slot_valid) begin
      ran = slot_task;
      lv  = slot_level;
      refill_slot();
      sum = {1'b0, ran.runtime} + {1'b0, quantum_cfg[lv-1]};
      if (sum > {1'b0, ran.need}) sum = {1'b0, ran.need};
      ran.runtime = sum[TIME_W-1:0];
      if (lv < LEVELS) lv++;
      pushed = 1'b0;
      if (ran.runtime < ran.need && level_fifo[lv-1].size() < QUEUE_DEPTH) begin
        level_fifo[lv-1].push_back(ran);
        pushed = 1'b1;
      end
      if (!slot_valid && pushed) refill_slot();
      res.ran_valid   = 1'b1;
      res.ran_id      = ran.id;
      res.ran_runtime = ran.runtime;
      res.ran_level   = LVL_W'(lv);
      res.finished    = (ran.runtime == ran.need);
    end
    res.idle = !slot_valid && level_fifo[0].size() == 0 && level_fifo[1].size() == 0 &&
               level_fifo[2].size() == 0;
    return res;
  endfunction

  // result receiver: random stalls, changed on the falling edge
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // compare every result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    sched_result_t got;
    sched_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.add_accepted, out_ch.ran_valid, out_ch.ran_id, out_ch.ran_runtime,
              out_ch.ran_level, out_ch.finished, out_ch.idle};
      if (expected_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: acc=%0b ran=%0b id=%0h rt=%0d lvl=%0d fin=%0b idle=%0b",
                   got.add_accepted, got.ran_valid, got.ran_id, got.ran_runtime,
                   got.ran_level, got.finished, got.idle);
      end else begin
        want = expected_outcomes.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: acc %0b/%0b ran %0b/%0b id %0h/%0h rt %0d/%0d",
                     $realtime, want.add_accepted, got.add_accepted, want.ran_valid,
                     got.ran_valid, want.ran_id, got.ran_id, want.ran_runtime,
                     got.ran_runtime);
            $display("  (expected/actual) lvl %0d/%0d fin %0b/%0b idle %0b/%0b",
                     want.ran_level, got.ran_level, want.finished, got.finished,
                     want.idle, got.idle);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // send one item; entered and left at a falling edge, valid left high
  task automatic send_item(input op_t op, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] need);
    sched_result_t res;
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.task_id   <= id;
    in_ch.need_time <= need;
    do @(posedge clk); while (!in_ch.ready);
    res = schedule_item(op, id, need);
    expected_outcomes.push_back(res);
    @(negedge clk);
  endtask

  task automatic add_task(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] need);
    send_item(OP_ADD, id, need);
  endtask

  task automatic run_steps(input int unsigned count);
    repeat (count) send_item(OP_STEP, ID_W'($urandom_range(255)),
                             TIME_W'($urandom_range(65535)));
  endtask

  // stop sending and wait until every result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // one register write; write enable stays high for back-to-back writes
  task automatic write_reg(input cfg_idx_t idx, input logic [TIME_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    quantum_cfg[idx] = val;
  endtask

  task automatic set_quanta(input logic [TIME_W-1:0] q1, input logic [TIME_W-1:0] q2,
                            input logic [TIME_W-1:0] q3);
    write_reg(CFG_QUANTUM_L1, q1);
    write_reg(CFG_QUANTUM_L2, q2);
    write_reg(CFG_QUANTUM_L3, q3);
    cfg_we <= 1'b0;
  endtask

  // step with nothing in the ready slot
  task automatic test_empty_step();
    run_steps(1);
    drain();
  endtask

  // extreme ids and needs through all three levels with the reset quanta
  task automatic test_level_walk();
    add_task(8'h00, 16'd1);
    add_task(8'hFF, 16'hFFFF);
    add_task(8'h5A, 16'd4);
    run_steps(5);
    drain();
  endtask

  // a task with zero need finishes on its first step
  task automatic test_zero_need();
    add_task(8'hA5, 16'd0);
    run_steps(2);
    drain();
  endtask

  // largest quanta clamp the runtime at the need
  task automatic test_quantum_clamp();
    set_quanta(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_steps(3);
    add_task(8'h3C, 16'hFFFF);
    run_steps(2);
    drain();
  endtask

  // zero quanta keep a task circulating without progress
  task automatic test_zero_quantum();
    set_quanta(16'd0, 16'd0, 16'd0);
    add_task(8'h33, 16'd2);
    add_task(8'hCC, 16'h8000);
    run_steps(4);
    drain();
  endtask

  function automatic logic [TIME_W-1:0] pick_need();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return TIME_W'($urandom_range(1, 8));
    if (r < 80) return TIME_W'($urandom_range(9, 300));
    if (r < 95) return TIME_W'($urandom_range(1, 65535));
    return ($urandom_range(1) != 0) ? 16'hFFFF : 16'd1;
  endfunction

  // bursts of adds and steps so the level fifos fill, overflow and drain
  task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
                                     input logic [TIME_W-1:0] q1,
                                     input logic [TIME_W-1:0] q2,
                                     input logic [TIME_W-1:0] q3,
                                     input int unsigned items);
    int unsigned done;
    int unsigned burst;
    logic        adding;
    logic        op_bit;
    set_quanta(q1, q2, q3);
    send_gap_pct = gap;
    stall_pct    = stall;
    done = 0;
    while (done < items) begin
      adding = ($urandom_range(99) < 50);
      burst  = adding ? $urandom_range(1, 20) : $urandom_range(1, 24);
      repeat (burst) begin
        if (done < items) begin
          // mostly the burst's own operation, some noise of the other kind
          op_bit = ($urandom_range(9) == 0) ? adding : !adding;
          send_item(op_t'(op_bit), ID_W'($urandom_range(255)), pick_need());
          done++;
        end
      end
    end
    drain();
    send_gap_pct = 0;
    stall_pct    = 0;
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_QUANTUM_L1;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_ADD;
    in_ch.task_id   = '0;
    in_ch.need_time = '0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    send_gap_pct    = 0;
    stall_pct       = 0;
    slot_valid      = 1'b0;
    slot_task       = '0;
    slot_level      = 1;
    quantum_cfg     = '{16'd1, 16'd2, 16'd3};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_step();
    test_level_walk();
    test_zero_need();
    test_quantum_clamp();
    test_zero_quantum();
    test_random_traffic(0, 0, 16'd1, 16'd2, 16'd3, 100);
    test_random_traffic(46, 0, 16'd1, 16'd1, 16'd1, 100);
    test_random_traffic(0, 46, TIME_W'($urandom_range(1, 65535)),
                        TIME_W'($urandom_range(1, 16)), 16'hFFFF, 100);
    test_random_traffic(21, 21, 16'hFFFF, TIME_W'($urandom_range(1, 65535)), 16'd1, 100);

    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
